### hdl/cba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

	localparam int ADDR_W  = 48;
	localparam int ALIGN_W = 17;
	localparam int CNT_W   = 7;
	// base + mark + align - 1 fits in this many bits
	localparam int TOP_W   = 50;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_OVERLAP = 2'd2;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	typedef struct packed {
		logic               action;
		logic [ADDR_W-1:0]  region_base;
		logic [ADDR_W-1:0]  region_size;
		logic [ADDR_W-1:0]  request_size;
		logic [ALIGN_W-1:0] alignment;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] address;
		logic [CNT_W-1:0]  region_count;
		logic [ADDR_W-1:0] free_bytes;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] mark;
	} region_row_t;

endpackage

`default_nettype wire

### hdl/chained_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Multi-region bump allocator. Pulse start while busy is low to hand in one
// transaction: an add appends a region (fails when the table is full or the
// new base falls inside an existing region, end inclusive), an allocate walks
// the regions in order and takes the first one where the watermark, rounded
// up to the alignment, leaves room for the request. Exactly one result comes
// back per transaction, on result for the single cycle that done is high; the
// receiver cannot stall it, so it must sample it then. busy stays high until
// the transaction ends; the bit-serial remainder unit used for every alignment
// dominates an allocate, and a closing sweep that totals free bytes visits
// every region. busy drops in the cycle that done is high, so the next
// transaction can start there. No clearing pass is needed after reset.
module chained_bump_allocator #(
	parameter int NUM_REGIONS = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cba_pkg::cmd_t    cmd,
	output logic                  done,
	output cba_pkg::result_t      result
);
	import cba_pkg::*;

	localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int ROW_W = $bits(region_row_t);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_ADD_RD  = 12'b0000_0000_0010,
		S_ADD_CHK = 12'b0000_0000_0100,
		S_ALC_RD  = 12'b0000_0000_1000,
		S_ALC_K   = 12'b0000_0001_0000,
		S_ALC_T   = 12'b0000_0010_0000,
		S_ALC_DIV = 12'b0000_0100_0000,
		S_ALC_SUB = 12'b0000_1000_0000,
		S_ALC_FIT = 12'b0001_0000_0000,
		S_SUM_RD  = 12'b0010_0000_0000,
		S_SUM_DIF = 12'b0100_0000_0000,
		S_SUM_ADD = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   used_q;
	logic               done_q;
	cmd_t               cmd_q;
	logic [ALIGN_W-1:0] align_q;
	logic [1:0]         status_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W:0]    k_q;
	logic [TOP_W-1:0]   t_q;
	logic [ADDR_W:0]    pend_q;
	logic [TOP_W-1:0]   abs_q;
	logic [ADDR_W-1:0]  diff_q;
	logic [ADDR_W-1:0]  acc_q;
	result_t            result_q;

	logic               accept;
	region_row_t        rd_row;
	logic [ROW_W-1:0]   rd_bits;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	region_row_t        ram_wdata;
	logic               div_start;
	logic               div_done;
	logic [ALIGN_W-1:0] div_rem;
	logic [TOP_W-1:0]   t_next;
	logic [ADDR_W:0]    end_incl;
	logic               overlap;
	logic [TOP_W-1:0]   nxt;
	logic               fits;
	logic               last;
	logic [ADDR_W:0]    acc_sum;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign rd_row = region_row_t'(rd_bits);
	assign last   = (idx_q + 1'b1) == used_q;

	assign end_incl = {1'b0, rd_row.base} + {1'b0, rd_row.size};
	assign overlap  = (cmd_q.region_base >= rd_row.base) &&
		({1'b0, cmd_q.region_base} <= end_incl);

	assign t_next    = TOP_W'(rd_row.base) + TOP_W'(k_q);
	assign div_start = (state_q == S_ALC_T);

	assign nxt  = TOP_W'(pend_q) + TOP_W'(cmd_q.request_size);
	assign fits = nxt <= TOP_W'(rd_row.size);

	assign acc_sum = {1'b0, acc_q} + {1'b0, diff_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = '{base: cmd_q.region_base, size: cmd_q.region_size, mark: '0};
		if (state_q == S_ADD_CHK && idx_q == used_q) begin
			ram_we = 1'b1;
		end else if (state_q == S_ALC_FIT && fits) begin
			ram_we    = 1'b1;
			ram_wdata = '{base: rd_row.base, size: rd_row.size, mark: nxt[ADDR_W-1:0]};
		end
	end

	cba_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(rd_bits)
	);

	cba_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(t_next),
		.divisor (align_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (cmd.action == ACT_ADD) begin
							if (used_q >= CNT_W'(NUM_REGIONS)) begin
								state_q <= S_SUM_RD;
							end else begin
								state_q <= S_ADD_RD;
							end
						end else if (used_q == '0) begin
							state_q <= S_SUM_RD;
						end else begin
							state_q <= S_ALC_RD;
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_CHK;
				S_ADD_CHK: begin
					if (idx_q == used_q) begin
						used_q  <= used_q + 1'b1;
						idx_q   <= '0;
						state_q <= S_SUM_RD;
					end else if (overlap) begin
						idx_q   <= '0;
						state_q <= S_SUM_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_ADD_RD;
					end
				end
				S_ALC_RD:  state_q <= S_ALC_K;
				S_ALC_K:   state_q <= S_ALC_T;
				S_ALC_T:   state_q <= S_ALC_DIV;
				S_ALC_DIV: begin
					if (div_done) begin
						state_q <= S_ALC_SUB;
					end
				end
				S_ALC_SUB: state_q <= S_ALC_FIT;
				S_ALC_FIT: begin
					if (fits || last) begin
						idx_q   <= '0;
						state_q <= S_SUM_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_ALC_RD;
					end
				end
				S_SUM_RD: begin
					if (idx_q == used_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SUM_DIF;
					end
				end
				S_SUM_DIF: state_q <= S_SUM_ADD;
				S_SUM_ADD: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SUM_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				if (accept) begin
					cmd_q   <= cmd;
					align_q <= (cmd.alignment == '0) ? ALIGN_W'(1) : cmd.alignment;
					addr_q  <= '0;
					if (cmd.action == ACT_ADD && used_q < CNT_W'(NUM_REGIONS)) begin
						status_q <= ST_OK;
					end else begin
						status_q <= ST_NOMEM;
					end
				end
			end
			S_ADD_CHK: begin
				if (idx_q != used_q && overlap) begin
					status_q <= ST_OVERLAP;
				end
			end
			// pending = mark + align - 1 - rem, address = base + pending
			S_ALC_K: k_q <= (ADDR_W + 1)'(rd_row.mark) + (ADDR_W + 1)'(align_q - 1'b1);
			S_ALC_T: t_q <= t_next;
			S_ALC_SUB: begin
				pend_q <= k_q - (ADDR_W + 1)'(div_rem);
				abs_q  <= t_q - TOP_W'(div_rem);
			end
			S_ALC_FIT: begin
				if (fits) begin
					status_q <= ST_OK;
					addr_q   <= abs_q[ADDR_W-1:0];
				end
			end
			S_SUM_DIF: diff_q <= rd_row.size - rd_row.mark;
			S_SUM_ADD: acc_q <= acc_sum[ADDR_W] ? '1 : acc_sum[ADDR_W-1:0];
			default: ;
		endcase
		if (state_q == S_SUM_RD && idx_q == used_q) begin
			result_q.status       <= status_q;
			result_q.address      <= addr_q;
			result_q.region_count <= used_q;
			result_q.free_bytes   <= acc_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### hdl/cba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/cba_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one dividend bit per cycle
module cba_mod_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cba_pkg::TOP_W-1:0]   dividend,
	input  wire logic [cba_pkg::ALIGN_W-1:0] divisor,
	output logic                             done,
	output logic      [cba_pkg::ALIGN_W-1:0] rem
);
	import cba_pkg::*;

	localparam int CW = $clog2(TOP_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [TOP_W-1:0]  dvd_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [ALIGN_W:0]  rem_sh;
	logic [ALIGN_W:0]  rem_sub;
	logic              take;

	assign rem_sh  = {rem_q, dvd_q[TOP_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign take    = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(TOP_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[TOP_W-2:0], 1'b0};
			rem_q <= take ? rem_sub[ALIGN_W-1:0] : rem_sh[ALIGN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire
